// ===== rtl/pcfl_pkg.sv =====
// shared types and constants for the per-class flood limiter
package pcfl_pkg;

   localparam int NUM_CLASSES = 6;
   localparam int ClassIdxW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   localparam int MsgClassW   = 3;
   localparam int TimeW       = 32;
   localparam int GapW        = 16;
   localparam int StrikeW     = 8;
   localparam int MuteW       = 20;
   localparam int CsrDataW    = 20;

   localparam logic [StrikeW-1:0] StrikeMax = {StrikeW{1'b1}};

   localparam logic [GapW-1:0]    FloodGapReset    = GapW'(1000);
   localparam logic [StrikeW-1:0] StrikeLimitReset = StrikeW'(5);
   localparam logic [MuteW-1:0]   MuteReset        = MuteW'(10000);
   localparam logic [GapW-1:0]    WarnGapReset     = GapW'(2000);

   typedef enum logic [1:0] {
      CFG_FLOOD_GAP    = 2'd0,
      CFG_STRIKE_LIMIT = 2'd1,
      CFG_MUTE         = 2'd2,
      CFG_WARN_GAP     = 2'd3
   } cfg_index_type;

   typedef struct packed {
      logic [GapW-1:0]    flood_gap;
      logic [StrikeW-1:0] strike_limit;
      logic [MuteW-1:0]   mute;
      logic [GapW-1:0]    warn_gap;
   } cfg_type;

   typedef struct packed {
      logic [TimeW-1:0]   last_event;
      logic [TimeW-1:0]   last_warn;
      logic [TimeW-1:0]   mute_until;
      logic [StrikeW-1:0] strike;
   } entry_type;

   typedef struct packed {
      logic muted;
      logic warn;
   } result_type;

endpackage

// ===== rtl/pcfl_req_if.sv =====
// request channel: message class and timestamp
interface pcfl_req_if;
   import pcfl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MsgClassW-1:0] msg_class;
   logic [TimeW-1:0]     now_ms;

   modport source (output valid, output msg_class, output now_ms, input ready);
   modport sink   (input valid, input msg_class, input now_ms, output ready);
endinterface

// ===== rtl/pcfl_rsp_if.sv =====
// response channel: muted and warn flags
interface pcfl_rsp_if;
   logic valid;
   logic ready;
   logic muted;
   logic warn;

   modport source (output valid, output muted, output warn, input ready);
   modport sink   (input valid, input muted, input warn, output ready);
endinterface

// ===== rtl/pcfl_update.sv =====
// per-class entry update: strike count, mute and warning decision
module pcfl_update (
   input  pcfl_pkg::entry_type            cur,
   input  pcfl_pkg::cfg_type              cfg,
   input  logic [pcfl_pkg::TimeW-1:0]     now_ms,
   output pcfl_pkg::entry_type            nxt,
   output pcfl_pkg::result_type           res
);
   import pcfl_pkg::*;

   logic [TimeW-1:0]   ev_diff;
   logic [TimeW-1:0]   warn_diff;
   logic [TimeW-1:0]   mute_diff;
   logic               strike_hit;
   logic [StrikeW-1:0] strike_inc;
   logic               mute_hit;
   logic               warn_due;

   always_comb begin
      ev_diff    = now_ms - cur.last_event;
      // negative gap counts as a strike too
      strike_hit = ev_diff[TimeW-1] || (ev_diff < TimeW'(cfg.flood_gap));
      strike_inc = cur.strike;
      if (strike_hit && (cur.strike != StrikeMax)) begin
         strike_inc = cur.strike + StrikeW'(1);
      end
      mute_hit  = (strike_inc >= cfg.strike_limit);
      mute_diff = now_ms - cur.mute_until;
      warn_diff = now_ms - cur.last_warn;
      warn_due  = !warn_diff[TimeW-1] && (warn_diff > TimeW'(cfg.warn_gap));

      nxt            = cur;
      nxt.last_event = now_ms;
      nxt.strike     = strike_inc;
      res            = '0;
      if (mute_hit) begin
         nxt.mute_until = now_ms + TimeW'(cfg.mute);
         nxt.strike     = '0;
         // now minus (now + mute) is negative exactly when mute is nonzero
         res.muted      = |cfg.mute;
      end else begin
         res.muted      = mute_diff[TimeW-1];
      end
      if (res.muted && warn_due) begin
         nxt.last_warn = now_ms;
         res.warn      = 1'b1;
      end
   end
endmodule

// ===== rtl/per_class_flood_limiter.sv =====
// top level of the per-class flood limiter: class table, pipeline and config registers
//
// Takes one item per clock while the response side is not stalled: each item
// names a message class and carries a millisecond timestamp, and gets exactly
// one response with muted and warn. Throughput is one item per cycle under
// the same condition. An item goes through the input register and then the
// response register, which shows its response; a held response stalls both.
// The rate is set by the single read-modify-write of the class table entry,
// done between those two registers, so a following item of the same class
// always sees the updated entry. The class table lives in flip-flops and is
// cleared by reset. Class codes at or above the number of classes are treated
// as class 0. The user must write configuration registers through the csr port
// while no item is in flight; the block itself does not enforce this.
module per_class_flood_limiter (
   input  logic                            clock,
   input  logic                            reset,
   pcfl_req_if.sink                        req_ch,
   pcfl_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  pcfl_pkg::cfg_index_type         csr_index,
   input  logic [pcfl_pkg::CsrDataW-1:0]   csr_wdata
);
   import pcfl_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   // class table, one entry per class
   entry_type table_ff [NUM_CLASSES];

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [ClassIdxW-1:0] s1_idx_ff;
   logic [TimeW-1:0]     s1_now_ff;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff;

   // handshake and update signals
   logic                 req_fire;
   logic                 s2_open;
   logic                 s1_fire;
   logic [ClassIdxW-1:0] req_idx;
   entry_type            cur_entry;
   entry_type            nxt_entry;
   result_type           upd_res;

   // output side can take an item when empty or draining this cycle
   always_comb begin
      s2_open      = !rsp_valid_ff || rsp_ch.ready;
      s1_fire      = s1_valid_ff && s2_open;
      req_ch.ready = !s1_valid_ff || s2_open;
      req_fire     = req_ch.valid && req_ch.ready;
      // out-of-range classes fold onto class 0
      if (32'(req_ch.msg_class) < NUM_CLASSES) begin
         req_idx = ClassIdxW'(req_ch.msg_class);
      end else begin
         req_idx = '0;
      end
      s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
      cur_entry    = table_ff[s1_idx_ff];
   end

   pcfl_update u_update (
      .cur    (cur_entry),
      .cfg    (cfg_ff),
      .now_ms (s1_now_ff),
      .nxt    (nxt_entry),
      .res    (upd_res)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flood_gap    <= FloodGapReset;
         cfg_ff.strike_limit <= StrikeLimitReset;
         cfg_ff.mute         <= MuteReset;
         cfg_ff.warn_gap     <= WarnGapReset;
      end else if (csr_we) begin
         case (csr_index)
            CFG_FLOOD_GAP:    cfg_ff.flood_gap    <= csr_wdata[GapW-1:0];
            CFG_STRIKE_LIMIT: cfg_ff.strike_limit <= csr_wdata[StrikeW-1:0];
            CFG_MUTE:         cfg_ff.mute         <= csr_wdata[MuteW-1:0];
            CFG_WARN_GAP:     cfg_ff.warn_gap     <= csr_wdata[GapW-1:0];
            default: ;
         endcase
      end
   end

   // class table: write back the updated entry as the item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            table_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         table_ff[s1_idx_ff] <= nxt_entry;
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_idx_ff <= req_idx;
         s1_now_ff <= req_ch.now_ms;
      end
      if (s1_fire) begin
         rsp_res_ff <= upd_res;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.muted = rsp_res_ff.muted;
   assign rsp_ch.warn  = rsp_res_ff.warn;

   // a warning is only ever raised for a muted item
   a_warn_needs_mute: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_res_ff.warn || rsp_res_ff.muted))
      else $error("warn raised without muted");

   // after an update the stored strike count sits below the limit
   a_strike_below_limit: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> ((table_ff[$past(s1_idx_ff)].strike < $past(cfg_ff.strike_limit))
                   || ($past(cfg_ff.strike_limit) == '0)))
      else $error("strike count left at or above limit");

   // a warning records its time in the class entry
   a_warn_time_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && upd_res.warn) |=>
         (table_ff[$past(s1_idx_ff)].last_warn == $past(s1_now_ff)))
      else $error("warning time not stored");

   // every item leaving the input register lands in the response register
   a_item_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (rsp_valid_ff && (rsp_res_ff == $past(upd_res))))
      else $error("response register missed an item");
endmodule
